@@ hdl/bsrg_pkg.sv @@
// Shared types, codes and constants for the single-resource grant unit.
package bsrg_pkg;

    localparam int          PROCS_DEF   = 16;
    localparam logic [7:0]  CAP_RESET   = 8'd10;
    localparam int          WORK_W      = 9;
    localparam int          PADDR_W     = 3;
    localparam logic        REG_CAPACITY = 1'b0;

    typedef enum logic {
        CMD_DECLARE = 1'b0,
        CMD_REQUEST = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_NEED   = 2'd1,
        ST_NONE_FREE = 2'd2,
        ST_UNSAFE    = 2'd3
    } t_status;

    typedef struct packed {
        logic       cmd;
        logic [3:0] process_id;
        logic [7:0] claim_units;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] free_after;
    } t_result;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DECLARE,
        OP_GRANT,
        OP_ROLLBACK
    } t_cell_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op   op;
        logic [3:0] pid;
        logic [7:0] claim;
        logic       clear_done;
        logic       kill;
    } t_cell_ctl;

    // safety-scan token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [WORK_W-1:0] work;
    } t_link;

    // per-cell status back to the controller
    typedef struct packed {
        logic hit;
        logic done;
        logic sel_zero;
    } t_cell_stat;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DECIDE,
        FSM_INJECT,
        FSM_SCAN
    } t_state;

endpackage

@@ hdl/bsrg_cell.sv @@
// One process cell: holds held units, remaining need and the finished flag.
module bsrg_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsrg_pkg::t_cell_ctl i_ctl,
    input  bsrg_pkg::t_link     i_link,
    output bsrg_pkg::t_link     o_link,
    output bsrg_pkg::t_cell_stat o_stat
);
    import bsrg_pkg::*;

    logic [7:0]        r_held, n_held;
    logic [7:0]        r_need, n_need;
    logic              r_done, n_done;
    logic              r_valid, n_valid;
    logic [WORK_W-1:0] r_work, n_work;
    logic              w_sel;
    logic              w_hit;

    // decode the broadcast and process a passing token
    always_comb begin
        w_sel   = (int'(i_ctl.pid) == IDX);
        w_hit   = i_link.valid && !r_done && ({1'b0, r_need} <= i_link.work);
        n_held  = r_held;
        n_need  = r_need;
        case (i_ctl.op)
            OP_CLEAR: begin
                n_held = '0;
                n_need = '0;
            end
            OP_DECLARE: begin
                if (w_sel) begin
                    n_need = (i_ctl.claim > r_held) ? (i_ctl.claim - r_held) : '0;
                end
            end
            OP_GRANT: begin
                if (w_sel) begin
                    n_held = r_held + 8'd1;
                    n_need = r_need - 8'd1;
                end
            end
            OP_ROLLBACK: begin
                if (w_sel) begin
                    n_held = r_held - 8'd1;
                    n_need = r_need + 8'd1;
                end
            end
            default: begin
            end
        endcase
        n_done  = i_ctl.clear_done ? 1'b0 : (r_done | w_hit);
        n_valid = i_link.valid && !i_ctl.kill;
        n_work  = i_link.work + (w_hit ? {1'b0, r_held} : {WORK_W{1'b0}});
    end

    // hold state and pass the token on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_need  <= '0;
            r_done  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_held  <= n_held;
            r_need  <= n_need;
            r_done  <= n_done;
            r_valid <= n_valid;
        end
        r_work <= n_work;
    end

    assign o_link.valid    = r_valid;
    assign o_link.work     = r_work;
    assign o_stat.hit      = w_hit;
    assign o_stat.done     = r_done;
    assign o_stat.sel_zero = w_sel && (r_need == 8'd0);

endmodule

@@ hdl/bsrg_ctrl.sv @@
// Controller: item decode, free-unit count, scan sequencing and result register.
module bsrg_ctrl #(
    parameter int PROCS = bsrg_pkg::PROCS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  bsrg_pkg::t_item                 i_item,
    input  logic                            i_cfg_wr,
    input  logic [7:0]                      i_cfg_data,
    input  bsrg_pkg::t_cell_stat [PROCS-1:0] i_stat,
    output bsrg_pkg::t_cell_ctl             o_ctl,
    output bsrg_pkg::t_link                 o_inject,
    output logic                            o_busy,
    output logic                            o_strobe,
    output bsrg_pkg::t_result               o_result
);
    import bsrg_pkg::*;

    localparam int IDLE_W = $clog2(PROCS + 1);

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    logic [7:0]        r_free, n_free;
    logic [IDLE_W-1:0] r_idle, n_idle;
    logic              r_strobe, n_strobe;
    t_result           r_result, n_result;
    logic              w_any_hit;
    logic              w_all_done;
    logic              w_sel_zero;
    logic              w_in_range;

    // gather cell status
    always_comb begin
        w_any_hit  = 1'b0;
        w_all_done = 1'b1;
        w_sel_zero = 1'b0;
        for (int i = 0; i < PROCS; i++) begin
            w_any_hit  = w_any_hit | i_stat[i].hit;
            w_all_done = w_all_done & i_stat[i].done;
            w_sel_zero = w_sel_zero | i_stat[i].sel_zero;
        end
        w_in_range = (int'(r_item.process_id) < PROCS);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FSM_IDLE;
            r_free   <= CAP_RESET;
            r_idle   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_idle   <= n_idle;
            r_strobe <= n_strobe;
        end
        r_item   <= n_item;
        r_result <= n_result;
    end

    // next state, cell commands and result
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_free   = r_free;
        n_idle   = r_idle;
        n_strobe = 1'b0;
        n_result = r_result;
        o_ctl.op         = OP_NONE;
        o_ctl.pid        = r_item.process_id;
        o_ctl.claim      = r_item.claim_units;
        o_ctl.clear_done = 1'b0;
        o_ctl.kill       = 1'b0;
        o_inject.valid   = 1'b0;
        o_inject.work    = {1'b0, r_free};
        case (r_state)
            FSM_IDLE: begin
                if (i_cfg_wr) begin
                    n_free   = i_cfg_data;
                    o_ctl.op = OP_CLEAR;
                end
                if (i_start) begin
                    n_item  = i_item;
                    n_state = FSM_DECIDE;
                end
            end
            FSM_DECIDE: begin
                n_state             = FSM_IDLE;
                n_strobe            = 1'b1;
                n_result.status     = ST_OK;
                n_result.free_after = r_free;
                if (r_item.cmd == CMD_DECLARE) begin
                    if (w_in_range) begin
                        o_ctl.op = OP_DECLARE;
                    end
                end else if (!w_in_range || w_sel_zero) begin
                    n_result.status = ST_NO_NEED;
                end else if (r_free == 8'd0) begin
                    n_result.status = ST_NONE_FREE;
                end else begin
                    // allocate tentatively, then scan
                    o_ctl.op         = OP_GRANT;
                    o_ctl.clear_done = 1'b1;
                    n_free           = r_free - 8'd1;
                    n_strobe         = 1'b0;
                    n_state          = FSM_INJECT;
                end
            end
            FSM_INJECT: begin
                o_inject.valid = 1'b1;
                n_idle         = w_any_hit ? '0 : IDLE_W'(1);
                n_state        = FSM_SCAN;
            end
            FSM_SCAN: begin
                n_result.free_after = r_free;
                if (w_all_done) begin
                    o_ctl.kill      = 1'b1;
                    n_strobe        = 1'b1;
                    n_result.status = ST_OK;
                    n_state         = FSM_IDLE;
                end else if (r_idle == IDLE_W'(PROCS)) begin
                    // a full lap without progress: roll back
                    o_ctl.kill          = 1'b1;
                    o_ctl.op            = OP_ROLLBACK;
                    n_free              = r_free + 8'd1;
                    n_strobe            = 1'b1;
                    n_result.status     = ST_UNSAFE;
                    n_result.free_after = r_free + 8'd1;
                    n_state             = FSM_IDLE;
                end else begin
                    n_idle = w_any_hit ? '0 : (r_idle + IDLE_W'(1));
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != FSM_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ hdl/bankers_single_resource_grant_unit.sv @@
// Top level: APB register, controller and the ring of process cells.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------
//  item in   | start && !busy             | i_item (cmd, id, claim)
//  result    | o_result_strobe, one cycle | o_result (status, free)
//  config    | psel, penable, pwrite      | paddr, pwdata / prdata
//
//  Declares and refused requests are settled in the DECIDE state, which sets the
//  registered result strobe on the way back to IDLE. A request that passes the
//  checks runs the scan token around the cell ring, one cell per cycle, until
//  all cells are finished or a full lap passes with no progress.
//  Reset is synchronous and restores capacity 10 with all cells cleared.
//  The receiver cannot stall; busy holds off new items until the result is out.
module bankers_single_resource_grant_unit #(
    parameter int PROCS = bsrg_pkg::PROCS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bsrg_pkg::t_item                i_item,
    output logic                           o_result_strobe,
    output bsrg_pkg::t_result              o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsrg_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import bsrg_pkg::*;

    logic [7:0]                  r_cap;
    logic                        w_cfg_wr;
    t_cell_ctl                   w_ctl;
    t_link                       w_inject;
    t_link                       w_ring_in;
    t_link     [PROCS-1:0]       w_link;
    t_cell_stat [PROCS-1:0]      w_stat;
    logic      [PROCS-1:0]       w_tok;

    // capacity register write
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else begin
            if (w_cfg_wr) begin
                r_cap <= pwdata[7:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {24'd0, r_cap} : 32'd0;

    bsrg_ctrl #(
        .PROCS (PROCS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .i_cfg_wr   (w_cfg_wr),
        .i_cfg_data (pwdata[7:0]),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl),
        .o_inject   (w_inject),
        .o_busy     (busy),
        .o_strobe   (o_result_strobe),
        .o_result   (o_result)
    );

    // close the ring; the controller injects a fresh token into cell zero
    assign w_ring_in = w_inject.valid ? w_inject : w_link[PROCS-1];

    for (genvar g = 0; g < PROCS; g++) begin : g_cell
        bsrg_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_link  ((g == 0) ? w_ring_in : w_link[(g == 0) ? 0 : g - 1]),
            .o_link  (w_link[g]),
            .o_stat  (w_stat[g])
        );
    end

    // gather the token valid bits
    always_comb begin
        for (int i = 0; i < PROCS; i++) begin
            w_tok[i] = w_link[i].valid;
        end
    end

`ifndef SYNTHESIS
    // at most one scan token circulates
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok) <= 1)
        else $error("more than one scan token in the ring");

    // a result appears only once the unit is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobe while busy");

    // one result per transaction
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe repeated");

    // an accepted transaction makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // no token left behind once idle
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> (w_tok == '0))
        else $error("scan token present while idle");
`endif

endmodule
